/* hw/rtl/lfu_cache_policy_assert.svh */
// Assertion macros shared by the verification files of the LFU cache.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef LFU_CACHE_POLICY_ASSERT_SVH
`define LFU_CACHE_POLICY_ASSERT_SVH

// Consequent checked at the same clock edge as the antecedent.
`define LCP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfu_cache_policy assertion failed");

// Consequent checked at the clock edge after the antecedent.
`define LCP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfu_cache_policy assertion failed");

`endif

/* hw/rtl/lcp_pkg.sv */
// Shared constants for the LFU cache with LRU tie-break.
// No dependencies; used by the top level and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package lcp_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 16;
   localparam int CSR_W   = 5;

   localparam int REQ_TDATA_W = KEY_W + VALUE_W;
   localparam int RSP_TDATA_W = VALUE_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
   localparam logic [CSR_W-1:0]   CSR_RESET  = 5'd16;
   localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

endpackage

`default_nettype wire

/* hw/rtl/lfu_cache_policy.sv */
// Key/value cache with least-frequently-used replacement and LRU tie-break.
// Depends on lcp_pkg for widths, command codes and constants.
//
//   channel  direction  transfer payload
//   req_*    in         tuser = cmd, tdata = key [31:0], value [63:32]
//   rsp_*    out        tuser = hit, tdata = value_out [31:0]
//   csr_*    in         csr_data = capacity_in_use, written whenever csr_valid is high
//
// Every request is served by scans over the entry memory, one entry per cycle
// through its single read port: a lookup scan, one eviction scan for each entry
// that must leave, and an update scan that rewrites counts and recency ranks.
// A get that misses ends after its lookup scan; a hit and a put run the update
// scan as well. req_tready is high only while no request is in work; the result
// register lets the next request be taken while a result still waits.
// Reset is synchronous and clears the valid bits, so the cache starts empty.
`timescale 1ns / 1ps
`default_nettype none

module lfu_cache_policy
   import lcp_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request channel.
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // key [31:0], value [63:32]
   input  wire logic                   req_tuser,   // cmd [0]
   // Result channel.
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0] rsp_tdata,   // value_out [31:0]
   output      logic                   rsp_tuser,   // hit [0]
   // Capacity register write channel.
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_W-1:0]       csr_data
);

   // Index into the entry store, and a counter that can also hold CAPACITY.
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   // Ranks of valid entries are always 0..n-1 with n at most CAPACITY.
   localparam int RANK_W = IDX_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LOOKUP = 3'd1;
   localparam logic [2:0] S_EVICT  = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;
      logic [RANK_W-1:0]  rank;
   } entry_type;

   // Entry store: no reset, every slot is written in the same cycle that its valid bit is set.
   entry_type entry_mem [CAPACITY];

   logic [2:0]          state_ff, state_in;
   logic [CSR_W-1:0]    csr_ff;

   // Captured request.
   logic                cmd_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [VALUE_W-1:0]  value_ff;

   // Scan pipeline: issue address, then registered read data in the following cycle.
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                proc_ff;
   logic [IDX_W-1:0]    proc_idx_ff;
   logic                rd_valid_ff;
   entry_type           rdata_ff;
   logic                last_entry;

   logic [CAPACITY-1:0] valid_ff, valid_in;

   // Results gathered over a scan.
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0]   hit_rank_ff, hit_rank_in;
   logic [VALUE_W-1:0]  hit_value_ff, hit_value_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic                vic_found_ff, vic_found_in;
   logic [IDX_W-1:0]    vic_idx_ff, vic_idx_in;
   logic [COUNT_W-1:0]  vic_count_ff, vic_count_in;
   logic [RANK_W-1:0]   vic_rank_ff, vic_rank_in;
   logic                free_found_ff, free_found_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   // Entry being evicted by the current eviction scan.
   logic [IDX_W-1:0]    ev_idx_ff, ev_idx_in;
   logic [RANK_W-1:0]   ev_rank_ff, ev_rank_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;

   logic                mem_we;
   entry_type           mem_wdata;
   logic [CNT_W-1:0]    eff_cap;
   logic                ev_slot;
   logic                live;
   logic [RANK_W-1:0]   live_rank;
   logic                better;
   logic                rsp_load;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_hit_ff;

   // A capacity of zero acts as one, and one above CAPACITY acts as CAPACITY.
   always_comb begin
      if (csr_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(csr_ff) > 32'(CAPACITY)) begin
         eff_cap = CNT_W'(CAPACITY);
      end else begin
         eff_cap = CNT_W'(csr_ff);
      end
   end

   assign rd_en = ((state_ff == S_LOOKUP) || (state_ff == S_EVICT) ||
                   (state_ff == S_UPDATE)) && (issue_ff < CNT_W'(CAPACITY));
   assign rd_addr    = issue_ff[IDX_W-1:0];
   assign last_entry = proc_ff && (proc_idx_ff == IDX_W'(CAPACITY - 1));

   // During an eviction scan the evicted entry no longer counts, and every
   // entry that was less recent moves up by one rank.
   assign ev_slot   = (state_ff == S_EVICT) && (proc_idx_ff == ev_idx_ff);
   assign live      = rd_valid_ff && !ev_slot;
   assign live_rank = ((state_ff == S_EVICT) && (rdata_ff.rank > ev_rank_ff)) ?
                      rdata_ff.rank - RANK_W'(1) : rdata_ff.rank;
   // Lowest count wins; among equal counts the highest rank (least recent).
   assign better    = !vic_found_ff || (rdata_ff.count < vic_count_ff) ||
                      ((rdata_ff.count == vic_count_ff) && (live_rank > vic_rank_ff));

   always_comb begin
      state_in      = state_ff;
      issue_in      = rd_en ? issue_ff + CNT_W'(1) : issue_ff;
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rank_in   = hit_rank_ff;
      hit_value_in  = hit_value_ff;
      occ_in        = occ_ff;
      vic_found_in  = vic_found_ff;
      vic_idx_in    = vic_idx_ff;
      vic_count_in  = vic_count_ff;
      vic_rank_in   = vic_rank_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      ev_idx_in     = ev_idx_ff;
      ev_rank_in    = ev_rank_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_load      = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = rdata_ff;

      // Occupancy, victim and first free slot are gathered by lookup and
      // eviction scans alike.
      if (proc_ff && ((state_ff == S_LOOKUP) || (state_ff == S_EVICT))) begin
         if (live) begin
            occ_in = occ_ff + CNT_W'(1);
            if (better) begin
               vic_found_in = 1'b1;
               vic_idx_in   = proc_idx_ff;
               vic_count_in = rdata_ff.count;
               vic_rank_in  = live_rank;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = proc_idx_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in      = S_LOOKUP;
               issue_in      = '0;
               hit_in        = 1'b0;
               occ_in        = '0;
               vic_found_in  = 1'b0;
               free_found_in = 1'b0;
            end
         end
         S_LOOKUP: begin
            if (proc_ff && rd_valid_ff && (rdata_ff.key == key_ff)) begin
               hit_in       = 1'b1;
               hit_idx_in   = proc_idx_ff;
               hit_rank_in  = rdata_ff.rank;
               hit_value_in = rdata_ff.value;
            end
            if (last_entry) begin
               if (hit_in) begin
                  state_in = S_UPDATE;
               end else if (cmd_ff == CMD_GET) begin
                  state_in = S_FINISH;
               end else if (occ_in >= eff_cap) begin
                  state_in   = S_EVICT;
                  ev_idx_in  = vic_idx_in;
                  ev_rank_in = vic_rank_in;
               end else begin
                  state_in = S_UPDATE;
               end
               issue_in      = '0;
               occ_in        = '0;
               vic_found_in  = 1'b0;
               free_found_in = 1'b0;
            end
         end
         S_EVICT: begin
            if (proc_ff) begin
               if (ev_slot) begin
                  valid_in[proc_idx_ff] = 1'b0;
               end else if (rd_valid_ff && (rdata_ff.rank > ev_rank_ff)) begin
                  mem_we         = 1'b1;
                  mem_wdata.rank = live_rank;
               end
            end
            if (last_entry) begin
               // A lowered capacity may call for several evictions in a row.
               if (occ_in >= eff_cap) begin
                  state_in   = S_EVICT;
                  ev_idx_in  = vic_idx_in;
                  ev_rank_in = vic_rank_in;
               end else begin
                  state_in = S_UPDATE;
               end
               issue_in      = '0;
               occ_in        = '0;
               vic_found_in  = 1'b0;
               free_found_in = 1'b0;
            end
         end
         S_UPDATE: begin
            if (proc_ff) begin
               if (hit_ff) begin
                  if (proc_idx_ff == hit_idx_ff) begin
                     mem_we         = 1'b1;
                     mem_wdata.rank = '0;
                     if (rdata_ff.count != COUNT_MAX) begin
                        mem_wdata.count = rdata_ff.count + COUNT_W'(1);
                     end
                     if (cmd_ff == CMD_PUT) begin
                        mem_wdata.value = value_ff;
                     end
                  end else if (rd_valid_ff && (rdata_ff.rank < hit_rank_ff)) begin
                     mem_we         = 1'b1;
                     mem_wdata.rank = rdata_ff.rank + RANK_W'(1);
                  end
               end else begin
                  if (proc_idx_ff == free_idx_ff) begin
                     mem_we                = 1'b1;
                     mem_wdata.key         = key_ff;
                     mem_wdata.value       = value_ff;
                     mem_wdata.count       = COUNT_W'(1);
                     mem_wdata.rank        = '0;
                     valid_in[proc_idx_ff] = 1'b1;
                  end else if (rd_valid_ff) begin
                     mem_we         = 1'b1;
                     mem_wdata.rank = rdata_ff.rank + RANK_W'(1);
                  end
               end
            end
            if (last_entry) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load   = 1'b1;
               rsp_hit_in = hit_ff;
               if (cmd_ff == CMD_GET) begin
                  rsp_value_in = hit_ff ? hit_value_ff : MISS_VALUE;
               end else begin
                  rsp_value_in = value_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_ff       <= CSR_RESET;
         issue_ff     <= CNT_W'(CAPACITY);
         proc_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         proc_ff      <= rd_en;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            csr_ff <= csr_data;
         end
      end
   end

   // Payload and scan bookkeeping; every field is set before it is used.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cmd_ff   <= req_tuser;
         key_ff   <= req_tdata[KEY_W-1:0];
         value_ff <= req_tdata[REQ_TDATA_W-1:KEY_W];
      end
      proc_idx_ff   <= rd_addr;
      rd_valid_ff   <= valid_ff[rd_addr];
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_rank_ff   <= hit_rank_in;
      hit_value_ff  <= hit_value_in;
      occ_ff        <= occ_in;
      vic_found_ff  <= vic_found_in;
      vic_idx_ff    <= vic_idx_in;
      vic_count_ff  <= vic_count_in;
      vic_rank_ff   <= vic_rank_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      ev_idx_ff     <= ev_idx_in;
      ev_rank_ff    <= ev_rank_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Entry store: one registered read and one write per cycle.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= entry_mem[rd_addr];
      end
      if (mem_we) begin
         entry_mem[proc_idx_ff] <= mem_wdata;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/lcp_checker.sv */
// Port-level checks on the LFU cache top level, attached by a bind statement.
// Depends on lcp_pkg and on the macros in lfu_cache_policy_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "lfu_cache_policy_assert.svh"

module lcp_checker
   import lcp_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tuser
);

   // After a request is taken, the block is busy in the next cycle.
   `LCP_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)

   // The block only goes busy because a request was taken.
   `LCP_ASSERT_NOW(a_busy_needs_req, $fell(req_tready), $past(req_tvalid))

   // A result appears exactly as the block becomes free again.
   `LCP_ASSERT_NOW(a_result_frees, $rose(rsp_tvalid), req_tready)

   // A waiting result holds still until it is taken.
   `LCP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

endmodule

bind lfu_cache_policy lcp_checker u_lcp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
